[src/sdds_pkg.sv]
// Shared types and constants for the signed decimal display scanner.
package sdds_pkg;

    // Symbol codes beyond the decimal digits
    localparam logic [3:0] SYM_MINUS = 4'd10;
    localparam logic [3:0] SYM_BLANK = 4'd11;

    // Divide by ten: q = (x * DIV10_MUL) >> DIV10_SHIFT, exact for 16-bit x
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    // What the current position shows
    typedef enum logic [2:0] {
        MODE_DIGIT = 3'b001,
        MODE_MINUS = 3'b010,
        MODE_BLANK = 3'b100
    } t_mode;

    // Quotient and remainder of a division by ten
    typedef struct packed {
        logic [15:0] quot;
        logic [3:0]  rem;
    } t_div10;

endpackage

[src/signed_decimal_display_scanner_unit.sv]
// Top level of the signed decimal display scanner: one display position per transfer.
//
//   channel   direction  valid           ready           payload
//   value     in         i_value_valid   o_value_ready   i_value (s16)
//   result    out        o_result_valid  i_result_ready  o_symbol, o_digit_on, o_digit_off
//
// One item per cycle unless the result stalls; input register, then result register.
// The cycle is set by the divide-by-ten multiply and remainder path in the compute stage.
// Reset (i_rst_n low, synchronous) clears both stage valids, the scan position, the
// previous position, the magnitude, the sign and sets digit mode.
// A stalled result holds in the result register; the input register still takes a
// transfer while it is empty, so one item can wait on each side of the compute stage.
module signed_decimal_display_scanner_unit #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_value_valid,
    output logic               o_value_ready,
    input  logic signed [15:0] i_value,
    output logic               o_result_valid,
    input  logic               i_result_ready,
    output logic [3:0]         o_symbol,
    output logic [1:0]         o_digit_on,
    output logic [1:0]         o_digit_off
);

    localparam logic [2:0] L_DIGITS = 3'(DIGIT_COUNT);
    localparam logic [1:0] L_LAST   = 2'(DIGIT_COUNT - 1);

    // Input stage: magnitude and sign worked out on the way in
    logic        r_in_valid;
    logic [15:0] r_in_abs;
    logic        r_in_neg;
    logic [15:0] w_raw;
    logic [15:0] n_in_abs;

    // Scanner state
    logic [1:0]      r_scan;
    logic [1:0]      r_last;
    logic [15:0]     r_mag;
    logic            r_neg;
    sdds_pkg::t_mode r_mode;
    logic [1:0]      n_scan;
    logic [15:0]     n_mag;
    logic            n_neg;
    sdds_pkg::t_mode n_mode;

    // Result register
    logic       r_out_valid;
    logic [3:0] r_out_symbol;
    logic [1:0] r_out_on;
    logic [1:0] r_out_off;
    logic [3:0] n_symbol;

    // Compute stage
    logic              w_adv;
    logic              w_in_take;
    logic [1:0]        w_pos;
    logic              w_sample;
    logic [15:0]       w_mag;
    logic              w_neg;
    sdds_pkg::t_mode   w_mode;
    sdds_pkg::t_div10  w_div;

    assign w_adv         = r_in_valid && (!r_out_valid || i_result_ready);
    assign o_value_ready = !r_in_valid || w_adv;
    assign w_in_take     = i_value_valid && o_value_ready;

    assign w_raw    = i_value;
    assign n_in_abs = w_raw[15] ? (~w_raw + 16'd1) : w_raw;

    // A position beyond the display counts as the first one
    assign w_pos    = ({1'b0, r_scan} >= L_DIGITS) ? 2'd0 : r_scan;
    assign w_sample = (w_pos == 2'd0);
    assign w_mag    = w_sample ? r_in_abs : r_mag;
    assign w_neg    = w_sample ? r_in_neg : r_neg;
    assign w_mode   = w_sample ? sdds_pkg::MODE_DIGIT : r_mode;

    sdds_div10 u_div10 (
        .i_dividend (w_mag),
        .o_res      (w_div)
    );

    always_comb begin
        n_scan   = (w_pos == L_LAST) ? 2'd0 : (w_pos + 2'd1);
        n_mag    = w_mag;
        n_neg    = w_neg;
        n_mode   = w_mode;
        n_symbol = sdds_pkg::SYM_BLANK;
        case (w_mode)
            sdds_pkg::MODE_DIGIT: begin
                n_symbol = w_div.rem;
                n_mag    = w_div.quot;
                if (w_div.quot == 16'd0) begin
                    n_mode = w_neg ? sdds_pkg::MODE_MINUS : sdds_pkg::MODE_BLANK;
                end
            end
            sdds_pkg::MODE_MINUS: begin
                n_symbol = sdds_pkg::SYM_MINUS;
                // sign on the last position stays until the next sample
                if (w_pos != L_LAST) begin
                    n_mode = sdds_pkg::MODE_BLANK;
                end
            end
            default: begin
                n_symbol = sdds_pkg::SYM_BLANK;
            end
        endcase
    end

    // Control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan      <= 2'd0;
            r_last      <= 2'd0;
            r_mag       <= 16'd0;
            r_neg       <= 1'b0;
            r_mode      <= sdds_pkg::MODE_DIGIT;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_scan <= n_scan;
                r_last <= w_pos;
                r_mag  <= n_mag;
                r_neg  <= n_neg;
                r_mode <= n_mode;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_abs <= n_in_abs;
            r_in_neg <= w_raw[15];
        end
        if (w_adv) begin
            r_out_symbol <= n_symbol;
            r_out_on     <= w_pos;
            r_out_off    <= r_last;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_symbol       = r_out_symbol;
    assign o_digit_on     = r_out_on;
    assign o_digit_off    = r_out_off;

endmodule

[src/sdds_div10.sv]
// Divide-by-ten unit: reciprocal multiply, remainder by back-multiply and subtract.
module sdds_div10 (
    input  logic [15:0]          i_dividend,
    output sdds_pkg::t_div10     o_res
);

    logic [31:0] w_prod;
    logic [15:0] w_quot;
    logic [15:0] w_back;
    logic [15:0] w_diff;

    assign w_prod = {16'd0, i_dividend} * {16'd0, sdds_pkg::DIV10_MUL};
    assign w_quot = {3'd0, w_prod[31:sdds_pkg::DIV10_SHIFT]};
    // q * 10 as q*8 + q*2
    assign w_back = {w_quot[12:0], 3'd0} + {w_quot[14:0], 1'b0};
    assign w_diff = i_dividend - w_back;

    assign o_res.quot = w_quot;
    assign o_res.rem  = w_diff[3:0];

endmodule

[src/sdds_checker.sv]
// Port-level checks for the signed decimal display scanner, bound to the top level.
module sdds_checker #(
    parameter int DIGIT_COUNT = 4
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_value_valid,
    input logic               o_value_ready,
    input logic signed [15:0] i_value,
    input logic               o_result_valid,
    input logic               i_result_ready,
    input logic [3:0]         o_symbol,
    input logic [1:0]         o_digit_on,
    input logic [1:0]         o_digit_off
);

    localparam logic [2:0] L_DIGITS = 3'(DIGIT_COUNT);

    logic       w_out_xfer;
    logic [1:0] r_prev_on;

    assign w_out_xfer = o_result_valid && i_result_ready;

    // position lit by the last result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_on <= 2'd0;
        end else if (w_out_xfer) begin
            r_prev_on <= o_digit_on;
        end
    end

    a_value_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_value_valid && !o_value_ready |=> i_value_valid && $stable(i_value))
        else $error("value changed while waiting for a transfer");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |=> o_result_valid && $stable(o_symbol)
            && $stable(o_digit_on) && $stable(o_digit_off))
        else $error("result changed while stalled");

    a_off_follows_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |-> o_digit_off == r_prev_on)
        else $error("digit_off is not the previously lit position");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_xfer |-> ({1'b0, o_digit_on} < L_DIGITS)
            && (o_digit_on == 2'd0 || o_digit_on == r_prev_on + 2'd1))
        else $error("scan position out of order");

    a_units_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_digit_on == 2'd0 |-> o_symbol <= 4'd9)
        else $error("units position shows no decimal digit");

endmodule

bind signed_decimal_display_scanner_unit sdds_checker #(.DIGIT_COUNT(DIGIT_COUNT)) u_sdds_checker (
    .*
);
